@@ design/imv_pkg.sv @@
// imv_pkg: shared types and constants of the ikev2 message validator
// no dependencies
package imv_pkg;

    localparam int HDR_BYTES = 28;

    localparam logic [7:0] EXCH_SA_INIT = 8'd34;
    localparam logic [7:0] EXCH_LAST    = 8'd37;
    localparam logic [7:0] PT_NONE      = 8'd0;
    localparam logic [7:0] PT_SA        = 8'd33;
    localparam logic [7:0] PT_A         = 8'd41;
    localparam logic [7:0] PT_B         = 8'd42;
    localparam logic [7:0] PT_C         = 8'd43;
    localparam logic [7:0] PT_D         = 8'd46;
    localparam logic [7:0] VERSION_2_0  = 8'h20;

    localparam logic [2:0] HS_OK       = 3'd0;
    localparam logic [2:0] HS_SHORT    = 3'd1;
    localparam logic [2:0] HS_LENGTH   = 3'd2;
    localparam logic [2:0] HS_VERSION  = 3'd3;
    localparam logic [2:0] HS_EXCHANGE = 3'd4;
    localparam logic [2:0] HS_PAYLOAD  = 3'd5;

    localparam logic [2:0] CS_OK      = 3'd0;
    localparam logic [2:0] CS_OVERRUN = 3'd1;
    localparam logic [2:0] CS_TRAIL   = 3'd2;
    localparam logic [2:0] CS_MISSING = 3'd3;
    localparam logic [2:0] CS_NOWALK  = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_GPH   = 3'd1,
        PH_PROP  = 3'd2,
        PH_TRANS = 3'd3,
        PH_PTAIL = 3'd4,
        PH_PSKIP = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [15:0] message_bytes;
        logic [3:0]  sa_bad_count;
        logic [3:0]  sa_seen_count;
        logic [7:0]  exchange_code;
        logic [2:0]  chain_status;
        logic [2:0]  header_status;
    } result_t;

endpackage

@@ design/imv_parser.sv @@
// imv_parser: header capture, payload chain walk and verdict logic, one beat per cycle while beat_en is high
// depends on imv_pkg
module imv_parser
    import imv_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          beat_en,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output result_t       result
);

    localparam int W  = OFFSET_BITS;
    localparam int XW = OFFSET_BITS + 18;
    localparam logic [W-1:0]  MAXC  = {W{1'b1}};
    localparam logic [31:0]   MAX32 = 32'(MAXC);

    typedef struct packed {
        phase_t       phase;
        logic [7:0]   cur_type;
        logic [7:0]   next_type;
        logic [W-1:0] pay_end;
        logic [W-1:0] body_end;
        logic [W-1:0] prop_end;
        logic         more;
        logic [7:0]   tleft;
        logic [W-1:0] nss;
        logic [15:0]  fa;
        logic [2:0]   cerr;
        logic         saerr;
        logic [3:0]   seen;
        logic [3:0]   bad;
    } walk_t;

    localparam walk_t WALK_RST = '{phase: PH_HDR, default: '0};

    walk_t        walk_reg, walk_next;
    logic [W-1:0] offset_reg, offset_next;
    logic [31:0]  decl_reg, decl_next;
    logic [7:0]   version_reg, version_next;
    logic [7:0]   exch_reg, exch_next;
    logic [7:0]   fpt_reg, fpt_next;

    function automatic walk_t f_chain_end(walk_t s, logic [2:0] code);
        walk_t r;
        r = s;
        r.cerr = code;
        r.phase = PH_DONE;
        return r;
    endfunction

    function automatic walk_t f_sa_fail(walk_t s);
        walk_t r;
        r = s;
        if (!r.saerr)
        begin
            r.saerr = 1'b1;
            if (r.bad != 4'd15)
                r.bad = r.bad + 4'd1;
        end
        r.phase = PH_PSKIP;
        return r;
    endfunction

    function automatic walk_t f_advance(walk_t s, logic [W-1:0] bp, logic [W-1:0] ep);
        walk_t r;
        r = s;
        if (r.cur_type == PT_NONE)
            r = f_chain_end(r, (bp < ep) ? CS_TRAIL : CS_OK);
        else if (bp >= ep)
            r = f_chain_end(r, CS_MISSING);
        else if (XW'(bp) + XW'(4) > XW'(ep))
            r = f_chain_end(r, CS_OVERRUN);
        else
        begin
            r.nss = bp;
            r.phase = PH_GPH;
        end
        return r;
    endfunction

    function automatic walk_t f_start_prop(walk_t s, logic [XW-1:0] at);
        walk_t r;
        r = s;
        if (at + XW'(8) >= XW'(r.body_end))
            r = f_sa_fail(r);
        else
        begin
            r.nss = at[W-1:0];
            r.phase = PH_PROP;
        end
        return r;
    endfunction

    function automatic walk_t f_prop_done(walk_t s);
        walk_t r;
        r = s;
        if (r.prop_end == r.body_end)
        begin
            if (r.more)
                r = f_sa_fail(r);
            else
                r.phase = PH_PSKIP;
        end
        else if (!r.more)
            r = f_sa_fail(r);
        else
            r = f_start_prop(r, XW'(r.prop_end));
        return r;
    endfunction

    function automatic walk_t f_resolve(walk_t s, logic [W-1:0] np, logic [W-1:0] ep);
        walk_t r;
        r = s;
        for (int i = 0; i < 2; i++)
        begin
            if (r.phase == PH_PSKIP && np == r.pay_end)
            begin
                r.cur_type = r.next_type;
                r = f_advance(r, r.pay_end, ep);
            end
            else if (r.phase == PH_PTAIL && np == r.prop_end)
                r = f_prop_done(r);
        end
        return r;
    endfunction

    function automatic walk_t f_walk(walk_t s, logic [W-1:0] pos, logic [7:0] b,
                                     logic [W-1:0] ep);
        walk_t         r;
        logic [W-1:0]  k;
        logic [15:0]   len;
        logic [XW-1:0] ns;
        r = s;
        k = pos - r.nss;
        len = {r.fa[7:0], b};
        ns = '0;
        if (pos >= r.nss)
        begin
            case (r.phase)
                PH_GPH:
                begin
                    if (k == W'(0))
                        r.next_type = b;
                    else if (k == W'(2))
                        r.fa = {8'd0, b};
                    else if (k == W'(3))
                    begin
                        if (len < 16'd4 || XW'(r.nss) + XW'(len) > XW'(ep))
                            r = f_chain_end(r, CS_OVERRUN);
                        else
                        begin
                            r.pay_end = W'(XW'(r.nss) + XW'(len));
                            if (r.cur_type == PT_SA)
                            begin
                                if (r.seen != 4'd15)
                                    r.seen = r.seen + 4'd1;
                                r.saerr = 1'b0;
                                r.body_end = r.pay_end;
                                r = f_start_prop(r, XW'(r.nss) + XW'(4));
                            end
                            else
                                r.phase = PH_PSKIP;
                        end
                    end
                end
                PH_PROP:
                begin
                    if (k == W'(0))
                        r.more = (b != 8'd0);
                    else if (k == W'(2))
                        r.fa = {8'd0, b};
                    else if (k == W'(3))
                        r.fa = len;
                    else if (k == W'(6))
                        r.tleft = b;
                    else if (k == W'(7))
                    begin
                        if (XW'(r.fa) < XW'(8) + XW'(r.tleft)
                            || XW'(r.nss) + XW'(r.fa) > XW'(r.body_end))
                            r = f_sa_fail(r);
                        else
                        begin
                            r.prop_end = W'(XW'(r.nss) + XW'(r.fa));
                            ns = XW'(r.nss) + XW'(8) + XW'(r.tleft);
                            r.tleft = b;
                            if (b == 8'd0)
                                r.phase = PH_PTAIL;
                            else if (ns + XW'(8) > XW'(r.prop_end))
                                r = f_sa_fail(r);
                            else
                            begin
                                r.nss = ns[W-1:0];
                                r.phase = PH_TRANS;
                            end
                        end
                    end
                end
                PH_TRANS:
                begin
                    if (k == W'(2))
                        r.fa = {8'd0, b};
                    else if (k == W'(3))
                        r.fa = len;
                    else if (k == W'(7))
                    begin
                        if (r.fa < 16'd8)
                            r = f_sa_fail(r);
                        else
                        begin
                            ns = XW'(r.nss) + XW'(r.fa);
                            r.tleft = r.tleft - 8'd1;
                            if (r.tleft == 8'd0)
                                r.phase = PH_PTAIL;
                            else if (ns + XW'(8) > XW'(r.prop_end))
                                r = f_sa_fail(r);
                            else
                                r.nss = ns[W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    logic [W-1:0] mend;
    logic         walked;

    always_comb
    begin
        walk_next    = walk_reg;
        offset_next  = offset_reg;
        decl_next    = decl_reg;
        version_next = version_reg;
        exch_next    = exch_reg;
        fpt_next     = fpt_reg;
        if (offset_reg != MAXC)
        begin
            if (offset_reg < W'(HDR_BYTES))
            begin
                if (offset_reg == W'(16))
                    fpt_next = data_byte;
                else if (offset_reg == W'(17))
                    version_next = data_byte;
                else if (offset_reg == W'(18))
                    exch_next = data_byte;
                else if (offset_reg >= W'(24))
                    decl_next = {decl_reg[23:0], data_byte};
            end
            mend = (decl_next < MAX32) ? decl_next[W-1:0] : MAXC;
            if (offset_reg < W'(HDR_BYTES))
            begin
                if (offset_reg == W'(HDR_BYTES - 1))
                begin
                    if (exch_next == EXCH_SA_INIT)
                    begin
                        walk_next.cur_type = fpt_next;
                        walk_next = f_advance(walk_next, W'(HDR_BYTES), mend);
                    end
                    else
                        walk_next = f_chain_end(walk_next, CS_NOWALK);
                end
            end
            else
                walk_next = f_walk(walk_next, offset_reg, data_byte, mend);
            walk_next = f_resolve(walk_next, offset_reg + W'(1), mend);
            offset_next = offset_reg + W'(1);
        end
        else
            mend = MAXC;

        if (offset_next < W'(HDR_BYTES))
            result.header_status = HS_SHORT;
        else if (offset_next == MAXC || 32'(offset_next) != decl_next)
            result.header_status = HS_LENGTH;
        else if (version_next != VERSION_2_0)
            result.header_status = HS_VERSION;
        else if (exch_next < EXCH_SA_INIT || exch_next > EXCH_LAST)
            result.header_status = HS_EXCHANGE;
        else if (!(fpt_next inside {PT_NONE, PT_SA, PT_A, PT_B, PT_C, PT_D}))
            result.header_status = HS_PAYLOAD;
        else
            result.header_status = HS_OK;
        walked = (result.header_status == HS_OK) && (exch_next == EXCH_SA_INIT);
        result.chain_status  = !walked ? CS_NOWALK :
                               (walk_next.phase == PH_DONE) ? walk_next.cerr : CS_OVERRUN;
        result.sa_seen_count = walked ? walk_next.seen : 4'd0;
        result.sa_bad_count  = walked ? walk_next.bad : 4'd0;
        result.exchange_code = exch_next;
        result.message_bytes = (XW'(offset_next) > XW'(16'hFFFF)) ? 16'hFFFF
                                                                 : 16'(XW'(offset_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg    <= WALK_RST;
            offset_reg  <= '0;
            decl_reg    <= '0;
            version_reg <= '0;
            exch_reg    <= '0;
            fpt_reg     <= '0;
        end
        else if (beat_en)
        begin
            if (last_byte)
            begin
                walk_reg    <= WALK_RST;
                offset_reg  <= '0;
                decl_reg    <= '0;
                version_reg <= '0;
                exch_reg    <= '0;
                fpt_reg     <= '0;
            end
            else
            begin
                walk_reg    <= walk_next;
                offset_reg  <= offset_next;
                decl_reg    <= decl_next;
                version_reg <= version_next;
                exch_reg    <= exch_next;
                fpt_reg     <= fpt_next;
            end
        end
    end

endmodule

@@ design/ikev2_message_validator.sv @@
// channel  dir  tdata                              tlast      tuser
// s_axis   in   data_byte[7:0]                     last_byte  -
// m_axis   out  verdict fields, 40 bits            -          -
//
// one beat per cycle while s_axis_tready is high; the verdict appears in the cycle after the beat with tlast
// parser state and the verdict register sit around a single combinational step
// reset clears all parse state; after each verdict the parser returns to header
// a waiting verdict stalls input only when the next tlast beat would replace it
// ikev2_message_validator: top level, beat intake and verdict register
// depends on imv_pkg, imv_parser
module ikev2_message_validator
    import imv_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // header_status, chain_status, exchange_code,
                                        // sa_seen_count, sa_bad_count, message_bytes
);

    result_t result;
    result_t out_reg;
    logic    valid_reg;
    logic    beat;

    assign s_axis_tready = !valid_reg || m_axis_tready || !s_axis_tlast;
    assign beat = s_axis_tvalid && s_axis_tready;

    imv_parser #(.OFFSET_BITS(OFFSET_BITS)) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_en   (beat),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (beat && s_axis_tlast)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (beat && s_axis_tlast)
            out_reg <= result;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

endmodule

@@ design/imv_checker.sv @@
// imv_checker: port-level assertions on the validator, bound to the top level
// depends on imv_pkg, ikev2_message_validator
module imv_checker
    import imv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata
);

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("verdict without a final beat");

    a_nowalk: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != HS_OK |-> m_axis_tdata[5:3] == CS_NOWALK)
        else $error("chain walked despite header error");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:18] <= m_axis_tdata[17:14])
        else $error("more bad sa payloads than seen");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict dropped under stall");

endmodule

bind ikev2_message_validator imv_checker u_imv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for the ikev2 message validator, byte stream in, verdict out
// depends on imv_pkg and ikev2_message_validator; predicts verdicts with its own parser model
`timescale 1ns / 100ps
module tb_top;
    import imv_pkg::*;

    localparam int CNT_MAX = 65535;
    localparam int ITEM_TARGET = 1000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    ikev2_message_validator u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // parser model state
    int unsigned offs, decl_len, pay_end, body_end, prop_end, struct_at, fld;
    logic [7:0]  ver, exch, first_pt, cur_pt, nxt_pt, xf_left;
    phase_t      phase;
    logic        more_flag, sa_err;
    logic [2:0]  chain_code;
    logic [3:0]  seen_cnt, bad_cnt;

    result_t     verdict_q[$];
    result_t     last_pred;
    int          errors = 0;
    int          n_items = 0;
    bit          hold_rx = 0;
    logic [7:0]  msg[$];

    task automatic parser_clear();
        offs = 0; decl_len = 0; ver = 0; exch = 0; first_pt = 0;
        phase = PH_HDR; cur_pt = 0; nxt_pt = 0; pay_end = 0; body_end = 0;
        prop_end = 0; more_flag = 0; xf_left = 0; struct_at = 0; fld = 0;
        chain_code = CS_OK; sa_err = 0; seen_cnt = 0; bad_cnt = 0;
    endtask

    function automatic int unsigned walk_end();
        return decl_len < CNT_MAX ? decl_len : CNT_MAX;
    endfunction

    task automatic finish_chain(logic [2:0] code);
        chain_code = code;
        phase = PH_DONE;
    endtask

    task automatic mark_sa_bad();
        if (!sa_err) begin
            sa_err = 1;
            if (bad_cnt != 4'd15)
                bad_cnt++;
        end
        phase = PH_PSKIP;
    endtask

    task automatic next_payload(int unsigned at);
        if (cur_pt == PT_NONE)
            finish_chain(at < walk_end() ? CS_TRAIL : CS_OK);
        else if (at >= walk_end())
            finish_chain(CS_MISSING);
        else if (at + 4 > walk_end())
            finish_chain(CS_OVERRUN);
        else begin
            struct_at = at;
            phase = PH_GPH;
        end
    endtask

    task automatic open_proposal(int unsigned at);
        if (at + 8 >= body_end)
            mark_sa_bad();
        else begin
            struct_at = at;
            phase = PH_PROP;
        end
    endtask

    task automatic close_proposal();
        if (prop_end == body_end) begin
            if (more_flag)
                mark_sa_bad();
            else
                phase = PH_PSKIP;
        end else if (!more_flag)
            mark_sa_bad();
        else
            open_proposal(prop_end);
    endtask

    task automatic walk_octet(int unsigned pos, logic [7:0] b);
        int unsigned k, len, ns;
        if (pos < struct_at)
            return;
        k = pos - struct_at;
        case (phase)
            PH_GPH:
                if (k == 0)
                    nxt_pt = b;
                else if (k == 2)
                    fld = b;
                else if (k == 3) begin
                    len = ((fld << 8) | b) & 16'hffff;
                    if (len < 4 || struct_at + len > walk_end())
                        finish_chain(CS_OVERRUN);
                    else begin
                        pay_end = struct_at + len;
                        if (cur_pt == PT_SA) begin
                            if (seen_cnt != 4'd15)
                                seen_cnt++;
                            sa_err = 0;
                            body_end = pay_end;
                            open_proposal(struct_at + 4);
                        end else
                            phase = PH_PSKIP;
                    end
                end
            PH_PROP:
                if (k == 0)
                    more_flag = (b != 0);
                else if (k == 2)
                    fld = b;
                else if (k == 3)
                    fld = ((fld << 8) | b) & 16'hffff;
                else if (k == 6)
                    xf_left = b;
                else if (k == 7) begin
                    len = fld;
                    if (len < 8 + xf_left || struct_at + len > body_end)
                        mark_sa_bad();
                    else begin
                        prop_end = struct_at + len;
                        ns = struct_at + 8 + xf_left;
                        xf_left = b;
                        if (b == 0)
                            phase = PH_PTAIL;
                        else if (ns + 8 > prop_end)
                            mark_sa_bad();
                        else begin
                            struct_at = ns;
                            phase = PH_TRANS;
                        end
                    end
                end
            PH_TRANS:
                if (k == 2)
                    fld = b;
                else if (k == 3)
                    fld = ((fld << 8) | b) & 16'hffff;
                else if (k == 7) begin
                    if (fld < 8)
                        mark_sa_bad();
                    else begin
                        ns = struct_at + fld;
                        xf_left--;
                        if (xf_left == 0)
                            phase = PH_PTAIL;
                        else if (ns + 8 > prop_end)
                            mark_sa_bad();
                        else
                            struct_at = ns;
                    end
                end
            default: ;
        endcase
    endtask

    // one accepted beat; pushes a verdict on the last byte
    task automatic predict_beat(logic [7:0] b, logic last);
        int unsigned pos;
        result_t r;
        pos = offs;
        if (pos < CNT_MAX) begin
            if (pos < HDR_BYTES) begin
                if (pos == 16)
                    first_pt = b;
                else if (pos == 17)
                    ver = b;
                else if (pos == 18)
                    exch = b;
                else if (pos >= 24)
                    decl_len = (decl_len << 8) | b;
                if (pos == 27) begin
                    if (exch == EXCH_SA_INIT) begin
                        cur_pt = first_pt;
                        next_payload(HDR_BYTES);
                    end else
                        finish_chain(CS_NOWALK);
                end
            end else
                walk_octet(pos, b);
            forever begin
                if (phase == PH_PSKIP && pos + 1 == pay_end) begin
                    cur_pt = nxt_pt;
                    next_payload(pay_end);
                end else if (phase == PH_PTAIL && pos + 1 == prop_end)
                    close_proposal();
                else
                    break;
            end
            offs = pos + 1;
        end
        if (!last)
            return;
        if (offs < HDR_BYTES)
            r.header_status = HS_SHORT;
        else if (offs >= CNT_MAX || offs != decl_len)
            r.header_status = HS_LENGTH;
        else if (ver != VERSION_2_0)
            r.header_status = HS_VERSION;
        else if (exch < EXCH_SA_INIT || exch > EXCH_LAST)
            r.header_status = HS_EXCHANGE;
        else if (!(first_pt inside {PT_NONE, PT_SA, PT_A, PT_B, PT_C, PT_D}))
            r.header_status = HS_PAYLOAD;
        else
            r.header_status = HS_OK;
        if (r.header_status == HS_OK && exch == EXCH_SA_INIT) begin
            r.chain_status = (phase == PH_DONE) ? chain_code : CS_OVERRUN;
            r.sa_seen_count = seen_cnt;
            r.sa_bad_count = bad_cnt;
        end else begin
            r.chain_status = CS_NOWALK;
            r.sa_seen_count = '0;
            r.sa_bad_count = '0;
        end
        r.exchange_code = exch;
        r.message_bytes = 16'(offs);
        verdict_q.push_back(r);
        last_pred = r;
        parser_clear();
    endtask

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // output side: random stalls plus one long hold-off on request
    initial begin
        int g;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_rx) begin
                m_axis_tready <= 0;
                repeat (200) @(posedge clk);
                hold_rx = 0;
            end
            g = gap_len();
            if (g > 0 && $urandom_range(0, 1)) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge clk) begin
        result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[37:0];
            if (verdict_q.size() == 0) begin
                $error("verdict with none expected: %h", m_axis_tdata);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (got.header_status !== want.header_status) begin
                    $error("header_status exp %0d got %0d", want.header_status,
                           got.header_status);
                    errors++;
                end
                if (got.chain_status !== want.chain_status) begin
                    $error("chain_status exp %0d got %0d", want.chain_status,
                           got.chain_status);
                    errors++;
                end
                if (got.exchange_code !== want.exchange_code) begin
                    $error("exchange_code exp %0d got %0d", want.exchange_code,
                           got.exchange_code);
                    errors++;
                end
                if (got.sa_seen_count !== want.sa_seen_count) begin
                    $error("sa_seen_count exp %0d got %0d", want.sa_seen_count,
                           got.sa_seen_count);
                    errors++;
                end
                if (got.sa_bad_count !== want.sa_bad_count) begin
                    $error("sa_bad_count exp %0d got %0d", want.sa_bad_count,
                           got.sa_bad_count);
                    errors++;
                end
                if (got.message_bytes !== want.message_bytes) begin
                    $error("message_bytes exp %0d got %0d", want.message_bytes,
                           got.message_bytes);
                    errors++;
                end
            end
        end
    end

    // send one byte; valid stays high across back-to-back beats
    task automatic send_beat(logic [7:0] b, logic last, bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_items++;
        predict_beat(b, last);
    endtask

    task automatic send_msg(bit allow_gap);
        for (int i = 0; i < msg.size(); i++)
            send_beat(msg[i], i == msg.size() - 1, allow_gap);
    endtask

    function automatic void put16(int unsigned at, int unsigned v);
        msg[at] = v[15:8];
        msg[at + 1] = v[7:0];
    endfunction

    // header with given fields, declared length patched later
    task automatic build_header(logic [7:0] np, logic [7:0] ex, logic [7:0] vr);
        msg.delete();
        for (int i = 0; i < HDR_BYTES; i++)
            msg.push_back(8'($urandom));
        msg[16] = np; msg[17] = vr; msg[18] = ex;
    endtask

    function automatic void fix_length(int unsigned adj);
        int unsigned n;
        n = msg.size() + adj;
        msg[24] = n[31:24]; msg[25] = n[23:16]; msg[26] = n[15:8]; msg[27] = n[7:0];
    endfunction

    function automatic logic [7:0] rand_type();
        case ($urandom_range(0, 5))
            0: return PT_SA;
            1: return PT_A;
            2: return PT_B;
            3: return PT_D;
            4: return PT_C;
            default: return 8'($urandom);
        endcase
    endfunction

    // append an sa payload; bad > 0 may inject a random defect
    task automatic add_sa(logic [7:0] np, bit bad);
        int unsigned start, nprop, ps, nx, sp, tl, fault;
        start = msg.size();
        msg.push_back(np); msg.push_back(8'($urandom)); msg.push_back(8'd0);
        msg.push_back(8'd0);
        nprop = $urandom_range(1, 2);
        fault = bad ? $urandom_range(0, 4) : 99;
        for (int p = 0; p < nprop; p++) begin
            ps = msg.size();
            nx = $urandom_range(1, 3);
            sp = $urandom_range(0, 4);
            msg.push_back((p == nprop - 1) ? 8'd0 : 8'd2);
            msg.push_back(8'd0); msg.push_back(8'd0); msg.push_back(8'd0);
            msg.push_back(8'(p + 1)); msg.push_back(8'($urandom)); msg.push_back(8'(sp));
            msg.push_back(8'(nx));
            repeat (sp) msg.push_back(8'($urandom));
            for (int t = 0; t < nx; t++) begin
                tl = 8 + 4 * $urandom_range(0, 1);
                msg.push_back(t == nx - 1 ? 8'd0 : 8'd3); msg.push_back(8'd0);
                msg.push_back(8'd0); msg.push_back(8'(tl));
                repeat (tl - 4) msg.push_back(8'($urandom));
                if (fault == 0 && t == 0)
                    msg[msg.size() - tl + 3] = 8'($urandom_range(0, 7));
            end
            put16(ps + 2, msg.size() - ps);
            if (fault == 1 && p == 0)
                put16(ps + 2, $urandom_range(0, 7 + sp));
            if (fault == 2 && p == nprop - 1)
                msg[ps] = 8'd2;
            if (fault == 3 && p == 0 && nprop == 2)
                msg[ps] = 8'd0;
            if (fault == 4 && p == 0)
                msg[ps + 7] = 8'd40;
        end
        put16(start + 2, msg.size() - start);
    endtask

    task automatic add_plain(logic [7:0] np, int unsigned body);
        int unsigned start;
        start = msg.size();
        msg.push_back(np); msg.push_back(8'($urandom));
        msg.push_back(8'd0); msg.push_back(8'd0);
        repeat (body) msg.push_back(8'($urandom));
        put16(start + 2, 4 + body);
    endtask

    // well formed sa_init chain with random content and occasional defects
    task automatic build_chain();
        int unsigned n;
        logic [7:0] t, nt;
        n = $urandom_range(0, 4);
        t = (n == 0) ? PT_NONE : rand_type();
        build_header(t, EXCH_SA_INIT, VERSION_2_0);
        for (int i = 0; i < n; i++) begin
            nt = (i == n - 1) ? PT_NONE : rand_type();
            if (t == PT_SA)
                add_sa(nt, $urandom_range(0, 3) == 0);
            else
                add_plain(nt, $urandom_range(0, 12));
            t = nt;
        end
        fix_length(0);
        case ($urandom_range(0, 9))
            0: msg.push_back(8'($urandom));
            1: if (msg.size() > 29) void'(msg.pop_back());
            2: if (msg.size() > HDR_BYTES)
                   msg[$urandom_range(HDR_BYTES, msg.size() - 1)] = 8'($urandom);
            3: msg[msg.size() > 30 ? 30 : 27] = 8'($urandom);
            default: ;
        endcase
        if (msg[25] == 8'hff && $urandom_range(0, 1)) fix_length(0);
    endtask

    typedef struct {
        int          kind;
        logic [7:0]  a;
        bit          check;
        logic [2:0]  hs;
        logic [2:0]  cs;
    } row_t;

    localparam int K_SHORT = 0, K_HDR = 1, K_VER = 2, K_NP = 3, K_CHAIN = 4,
                   K_BADLEN = 5, K_ONEBYTE = 6, K_TRAIL = 7, K_MISSING = 8,
                   K_SHORTPL = 9;

    initial begin
        row_t rows[$];
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        parser_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        rows = '{
            '{K_ONEBYTE, 8'hff, 1, HS_SHORT,    CS_NOWALK},
            '{K_SHORT,   8'd27, 1, HS_SHORT,    CS_NOWALK},
            '{K_HDR,     8'd34, 1, HS_OK,       CS_OK},
            '{K_HDR,     8'd35, 1, HS_OK,       CS_NOWALK},
            '{K_HDR,     8'd36, 1, HS_OK,       CS_NOWALK},
            '{K_HDR,     8'd37, 1, HS_OK,       CS_NOWALK},
            '{K_HDR,     8'd33, 1, HS_EXCHANGE, CS_NOWALK},
            '{K_HDR,     8'd38, 1, HS_EXCHANGE, CS_NOWALK},
            '{K_HDR,     8'd0,  1, HS_EXCHANGE, CS_NOWALK},
            '{K_HDR,     8'hff, 1, HS_EXCHANGE, CS_NOWALK},
            '{K_VER,     8'h21, 1, HS_VERSION,  CS_NOWALK},
            '{K_VER,     8'h00, 1, HS_VERSION,  CS_NOWALK},
            '{K_NP,      8'd1,  1, HS_PAYLOAD,  CS_NOWALK},
            '{K_NP,      8'hff, 1, HS_PAYLOAD,  CS_NOWALK},
            '{K_BADLEN,  8'd0,  1, HS_LENGTH,   CS_NOWALK},
            '{K_TRAIL,   8'd0,  1, HS_OK,       CS_TRAIL},
            '{K_MISSING, 8'd0,  1, HS_OK,       CS_MISSING},
            '{K_SHORTPL, 8'd0,  1, HS_OK,       CS_OVERRUN},
            '{K_CHAIN,   8'd0,  0, 0, 0},
            '{K_CHAIN,   8'd0,  0, 0, 0},
            '{K_CHAIN,   8'd0,  0, 0, 0}
        };
        foreach (rows[i]) begin
            case (rows[i].kind)
                K_ONEBYTE: begin msg.delete(); msg.push_back(rows[i].a); end
                K_SHORT: begin
                    build_header(PT_NONE, EXCH_SA_INIT, VERSION_2_0);
                    void'(msg.pop_back());
                end
                K_HDR: begin build_header(PT_NONE, rows[i].a, VERSION_2_0); fix_length(0); end
                K_VER: begin build_header(PT_NONE, 8'd35, rows[i].a); fix_length(0); end
                K_NP: begin build_header(rows[i].a, 8'd35, VERSION_2_0); fix_length(0); end
                K_BADLEN: begin build_header(PT_NONE, 8'd34, VERSION_2_0); fix_length(1); end
                K_TRAIL: begin
                    build_header(PT_NONE, 8'd34, VERSION_2_0);
                    msg.push_back(8'hff); fix_length(0);
                end
                K_MISSING: begin build_header(PT_SA, 8'd34, VERSION_2_0); fix_length(0); end
                K_SHORTPL: begin
                    build_header(PT_A, 8'd34, VERSION_2_0);
                    msg.push_back(8'd0); msg.push_back(8'hff); msg.push_back(8'd0);
                    msg.push_back(8'd3);
                    fix_length(0);
                end
                default: build_chain();
            endcase
            send_msg(1);
            if (rows[i].check &&
                (last_pred.header_status != rows[i].hs ||
                 last_pred.chain_status != rows[i].cs)) begin
                $error("table row %0d: header_status exp %0d got %0d, chain_status exp %0d got %0d",
                       i, rows[i].hs, last_pred.header_status, rows[i].cs,
                       last_pred.chain_status);
                errors++;
            end
        end

        // long output hold-off while four short messages queue up
        hold_rx = 1;
        for (int i = 0; i < 4; i++) begin
            build_header(PT_NONE, 8'd36, VERSION_2_0); fix_length(0);
            send_msg(0);
        end
        s_axis_tvalid <= 0;
        // pause until every verdict has come back
        while (verdict_q.size() != 0)
            @(posedge clk);

        // random part: mostly valid sa_init chains, some header noise
        while (n_items < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    build_header(8'($urandom), 8'($urandom_range(32, 40)),
                                 $urandom_range(0, 3) ? 8'h20 : 8'($urandom));
                    repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom));
                    fix_length(($urandom_range(0, 3) == 0) ? 1 : 0);
                end
                1: begin
                    msg.delete();
                    repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom));
                end
                default: build_chain();
            endcase
            send_msg(1);
        end
        s_axis_tvalid <= 0;

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
